/* hdl/mipf_pkg.sv */
// Package: constants and types for the masked IPv4 filter table.
package mipf_pkg;
    localparam int MAX_FILTERS = 1024;
    localparam int IDX_W = $clog2(MAX_FILTERS);
    localparam int CNT_W = $clog2(MAX_FILTERS + 1);
    localparam int ENTRY_W = 64;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CHECK  = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_READ,
        S_DONE
    } state_t;

    function automatic logic [31:0] pattern_mask(input logic [31:0] a);
        logic [31:0] m;
        m = '0;
        for (int k = 0; k < 4; k++) begin
            if (a[8*k +: 8] != 8'd0) begin
                m[8*k +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction
endpackage

/* hdl/mipf_ram.sv */
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module mipf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hdl/masked_ip_filter_table.sv */
// Top level: masked IPv4 filter table with add, remove, check and read.
// Channels: s_axis_* carries one operation per item (op, address, entry index);
// m_axis_* returns one result per item; cfg_* writes ban_mode (bit 0).
// Entries sit in one RAM (compare and mask side by side, one read port,
// one write port, registered read). Each item is handled alone:
//   add, remove, check scan entries one per cycle; remove then moves
//   later entries down one per cycle; read fetches the entry at the
//   given index, or reports a miss when the index is out of range.
// The result is held in an output register until m_axis_tready; the next
// item is accepted only when that register is empty or its item leaves
// in the same cycle.
// Reset clears the count (table empty) and sets ban_mode to 1; the RAM is
// not cleared, entries beyond the count are never read.
module masked_ip_filter_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[1:0], address[33:2], entry_index[43:34], zero fill [47:44]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], blocked[2], entry_compare[34:3], entry_mask[66:35],
    // entry_count[77:67], zero fill [79:78]
    output logic [79:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import mipf_pkg::*;

    state_t state_reg, state_next;
    logic ban_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [1:0] op_reg;
    logic [31:0] addr_reg, mask_reg;
    logic [IDX_W-1:0] idx_reg;
    logic pend_reg, pend_next;
    logic [79:0] out_reg;
    logic out_valid_reg;

    logic ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    logic [31:0] rd_cmp, rd_mask;

    logic done;
    logic hit;
    logic [1:0] res_status;
    logic res_blocked;
    logic [31:0] res_cmp, res_mask;

    mipf_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_FILTERS)) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_cmp  = ram_rdata[31:0];
    assign rd_mask = ram_rdata[63:32];

    assign s_axis_tready = (state_reg == S_IDLE) && !(out_valid_reg && !m_axis_tready);
    assign cfg_ready = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_reg;

    logic accept;
    assign accept = s_axis_tvalid && s_axis_tready;

    assign hit = pend_reg && (
        (op_reg == OP_ADD && rd_cmp == ALL_ONES) ||
        (op_reg == OP_REMOVE && rd_mask == mask_reg && rd_cmp == addr_reg) ||
        (op_reg == OP_CHECK && (addr_reg & rd_mask) == rd_cmp));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = (s_axis_tdata[1:0] == OP_READ) ? S_READ : S_SCAN;
                end
            end
            S_READ: begin
                state_next = ({1'b0, idx_reg} < count_reg) ? S_DONE : S_IDLE;
            end
            S_DONE: begin
                state_next = S_IDLE;
            end
            S_SCAN: begin
                if (hit) begin
                    state_next = (op_reg == OP_REMOVE) ? S_SHIFT : S_IDLE;
                end else if (!(ptr_reg < count_reg)) begin
                    state_next = S_IDLE;
                end
            end
            S_SHIFT: begin
                if (!(ptr_reg < count_reg)) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // pend_reg: a RAM read was issued last cycle (entry ptr_reg-1 in scan and shift, idx_reg in read)
    always_comb begin
        count_next = count_reg;
        ptr_next = ptr_reg;
        pend_next = 1'b0;
        ram_we = 1'b0;
        ram_waddr = ptr_reg[IDX_W-1:0];
        ram_wdata = {mask_reg, addr_reg};
        ram_raddr = ptr_reg[IDX_W-1:0];
        done = 1'b0;
        res_status = ST_OK;
        res_blocked = 1'b0;
        res_cmp = '0;
        res_mask = '0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    ptr_next = '0;
                end
            end
            S_READ: begin
                ram_raddr = idx_reg;
                if ({1'b0, idx_reg} < count_reg) begin
                    pend_next = 1'b1;
                end else begin
                    res_status = ST_MISS;
                    done = 1'b1;
                end
            end
            S_DONE: begin
                res_cmp = rd_cmp;
                res_mask = rd_mask;
                done = 1'b1;
            end
            S_SCAN: begin
                if (hit) begin
                    case (op_reg)
                        OP_ADD: begin
                            ram_we = 1'b1;
                            ram_waddr = IDX_W'(ptr_reg - 1'b1);
                            done = 1'b1;
                        end
                        OP_REMOVE: begin
                            // ptr_reg-1 is the hole; read ptr_reg to move down
                            ram_raddr = ptr_reg[IDX_W-1:0];
                            pend_next = ptr_reg < count_reg;
                            ptr_next = ptr_reg + 1'b1;
                        end
                        default: begin
                            res_blocked = ban_reg;
                            done = 1'b1;
                        end
                    endcase
                end else if (ptr_reg < count_reg) begin
                    pend_next = 1'b1;
                    ptr_next = ptr_reg + 1'b1;
                end else begin
                    done = 1'b1;
                    case (op_reg)
                        OP_ADD: begin
                            if (count_reg == CNT_W'(MAX_FILTERS)) begin
                                res_status = ST_FULL;
                            end else begin
                                ram_we = 1'b1;
                                ram_waddr = count_reg[IDX_W-1:0];
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_REMOVE: res_status = ST_MISS;
                        default: res_blocked = !ban_reg;
                    endcase
                end
            end
            S_SHIFT: begin
                if (pend_reg) begin
                    ram_we = 1'b1;
                    ram_waddr = IDX_W'(ptr_reg - 2'd2);
                    ram_wdata = ram_rdata;
                end
                if (ptr_reg < count_reg) begin
                    ram_raddr = ptr_reg[IDX_W-1:0];
                    pend_next = 1'b1;
                    ptr_next = ptr_reg + 1'b1;
                end else begin
                    count_next = count_reg - 1'b1;
                    done = 1'b1;
                end
            end
            default: done = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ban_reg <= 1'b1;
            count_reg <= '0;
            ptr_reg <= '0;
            pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg <= ptr_next;
            pend_reg <= pend_next;
            if (cfg_valid) begin
                ban_reg <= cfg_data;
            end
            if (done) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg <= s_axis_tdata[1:0];
            addr_reg <= s_axis_tdata[33:2];
            mask_reg <= pattern_mask(s_axis_tdata[33:2]);
            idx_reg <= s_axis_tdata[43:34];
        end
        if (done) begin
            out_reg <= {2'b00, count_next, res_mask, res_cmp, res_blocked, res_status};
        end
    end
endmodule

/* hdl/mipf_checker.sv */
// Checker: port-level properties of the filter table, bound to the top level.
module mipf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata
);
    import mipf_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[77:67] <= 11'(MAX_FILTERS))
        else $error("count above capacity");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("bad status code");

    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while busy");
endmodule

bind masked_ip_filter_table mipf_checker u_mipf_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

/* bench/masked_ip_filter_table_test.sv */
// Testbench for the masked IPv4 filter table: random and directed items checked by a scoreboard.
`timescale 1ns / 100ps
module masked_ip_filter_table_test;
    import mipf_pkg::*;

    typedef struct packed {
        logic [10:0] entry_count;
        logic [31:0] entry_mask;
        logic [31:0] entry_compare;
        logic        blocked;
        logic [1:0]  status;
    } verdict_t;

    class filter_scoreboard;
        logic [31:0] cmp_q[$];
        logic [31:0] msk_q[$];
        logic        ban;
        verdict_t    pending[$];
        int          errors;

        function new();
            ban = 1'b1;
            errors = 0;
        endfunction

        function logic [31:0] octet_mask(logic [31:0] a);
            logic [31:0] m;
            m = '0;
            for (int k = 0; k < 4; k++) begin
                if (a[8*k +: 8] != 8'd0) begin
                    m[8*k +: 8] = 8'hFF;
                end
            end
            return m;
        endfunction

        function void note_item(op_t op, logic [31:0] addr, logic [9:0] idx);
            verdict_t v;
            int slot;
            logic [31:0] m;
            v = '0;
            m = octet_mask(addr);
            slot = -1;
            case (op)
                OP_ADD: begin
                    foreach (cmp_q[i]) begin
                        if (slot < 0 && cmp_q[i] == ALL_ONES) begin
                            slot = i;
                        end
                    end
                    if (slot >= 0) begin
                        cmp_q[slot] = addr;
                        msk_q[slot] = m;
                    end else if (cmp_q.size() >= MAX_FILTERS) begin
                        v.status = ST_FULL;
                    end else begin
                        cmp_q.push_back(addr);
                        msk_q.push_back(m);
                    end
                end
                OP_REMOVE: begin
                    v.status = ST_MISS;
                    foreach (cmp_q[i]) begin
                        if (slot < 0 && cmp_q[i] == addr && msk_q[i] == m) begin
                            slot = i;
                        end
                    end
                    if (slot >= 0) begin
                        cmp_q.delete(slot);
                        msk_q.delete(slot);
                        v.status = ST_OK;
                    end
                end
                OP_CHECK: begin
                    foreach (cmp_q[i]) begin
                        if ((addr & msk_q[i]) == cmp_q[i]) begin
                            slot = i;
                        end
                    end
                    v.blocked = (slot >= 0) ? ban : ~ban;
                end
                default: begin
                    if (idx < cmp_q.size()) begin
                        v.entry_compare = cmp_q[idx];
                        v.entry_mask = msk_q[idx];
                    end else begin
                        v.status = ST_MISS;
                    end
                end
            endcase
            v.entry_count = 11'(cmp_q.size());
            pending.push_back(v);
        endfunction

        function void check_result(logic [79:0] d);
            verdict_t got, want;
            got = d[77:0];
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: status %0d/%0d blocked %0d/%0d cmp %h/%h",
                        want.status, got.status, want.blocked, got.blocked,
                        want.entry_compare, got.entry_compare);
                    $display("          msk %h/%h cnt %0d/%0d",
                        want.entry_mask, got.entry_mask, want.entry_count,
                        got.entry_count);
                end
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;

    filter_scoreboard board = new();
    int  cycle_count = 0;
    int  hold_off = 0;
    bit  long_hold = 0;
    logic [31:0] pattern_pool[16];

    masked_ip_filter_table dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 4000000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            board.check_result(m_axis_tdata);
        end
    end

    initial begin
        int wait_n;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (long_hold) begin
                m_axis_tready <= 1'b0;
                hold_off = 0;
                while (hold_off < 400) begin
                    @(posedge aclk);
                    hold_off++;
                end
                long_hold = 0;
            end
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (wait_n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (wait_n) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
        end
    end

    task automatic send_item(op_t op, logic [31:0] addr, logic [9:0] idx, bit no_gap = 0);
        int wait_n;
        wait_n = no_gap ? 0 : $urandom_range(0, 19);
        if (wait_n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (wait_n) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'd0, idx, addr, op};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        board.note_item(op, addr, idx);
    endtask

    task automatic write_ban(logic value);
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.ban = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_pattern();
        logic [31:0] a;
        a = $urandom();
        for (int k = 0; k < 4; k++) begin
            if ($urandom_range(0, 2) == 0) a[8*k +: 8] = 8'd0;
        end
        return a;
    endfunction

    initial begin
        logic [31:0] a;
        int pick;
        op_t op;
        for (int i = 0; i < 16; i++) pattern_pool[i] = rand_pattern();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(OP_READ, 32'h0, 10'd0);
        send_item(OP_REMOVE, 32'h0102_0304, 10'd0);
        send_item(OP_CHECK, 32'hFFFF_FFFF, 10'd0);
        send_item(OP_ADD, 32'h0000_00C0, 10'd0);
        send_item(OP_ADD, 32'hFFFF_FFFF, 10'd0);
        send_item(OP_ADD, 32'h0000_0000, 10'd0);
        send_item(OP_CHECK, 32'h1234_56C0, 10'd0);
        send_item(OP_CHECK, 32'h1234_56C1, 10'd0);
        send_item(OP_READ, 32'h0, 10'd1);
        send_item(OP_READ, 32'h0, 10'd3);
        send_item(OP_READ, 32'h0, 10'h3FF);
        send_item(OP_ADD, 32'h0A00_0B0C, 10'd0);
        send_item(OP_READ, 32'h0, 10'd1);
        send_item(OP_REMOVE, 32'h0000_00C0, 10'd0);
        send_item(OP_REMOVE, 32'h0000_00C0, 10'd0);
        send_item(OP_READ, 32'h0, 10'd0);
        write_ban(1'b0);
        send_item(OP_CHECK, 32'h0A99_0B0C, 10'd0);
        send_item(OP_CHECK, 32'h0A99_0B0D, 10'd0);
        send_item(OP_REMOVE, 32'h0000_0000, 10'd0);
        send_item(OP_CHECK, 32'h5555_5555, 10'd0);

        long_hold = 1;
        for (int i = 0; i < 6; i++) send_item(OP_ADD, pattern_pool[i], 10'd0, 1);

        for (int phase = 0; phase < 4; phase++) begin
            write_ban(phase[0]);
            for (int i = 0; i < 139; i++) begin
                pick = $urandom_range(0, 15);
                op = op_t'($urandom_range(0, 3));
                case (op)
                    OP_ADD:
                        a = ($urandom_range(0, 7) == 0) ? ALL_ONES : pattern_pool[pick];
                    OP_REMOVE:
                        a = ($urandom_range(0, 4) == 0) ? $urandom() : pattern_pool[pick];
                    OP_CHECK:
                        a = ($urandom_range(0, 2) == 0) ? $urandom()
                            : (pattern_pool[pick] | ($urandom() & ~board.octet_mask(
                                pattern_pool[pick])));
                    default:
                        a = $urandom();
                endcase
                send_item(op, a, ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                    : 10'($urandom_range(0, 20)), $urandom_range(0, 3) == 0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (board.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

/* filelist.f */
hdl/mipf_pkg.sv
hdl/mipf_ram.sv
hdl/masked_ip_filter_table.sv
hdl/mipf_checker.sv
bench/masked_ip_filter_table_test.sv
